[sv/packet_deframer_xor_ring_assert.svh]
// ----------------------------------------------------------------------------
// packet_deframer_xor_ring_assert.svh
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_XOR_RING_ASSERT_SVH
`define PACKET_DEFRAMER_XOR_RING_ASSERT_SVH

// Checked only while out of reset.
`define PDXR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PDXR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/pdxr_pkg.sv]
// ----------------------------------------------------------------------------
// pdxr_pkg
// Shared constants and types of the packet deframer.
// ----------------------------------------------------------------------------
package pdxr_pkg;

    localparam int RING_SLOTS = 4;
    localparam int SLOT_BYTES = 256;

    localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int ADDR_W = $clog2(RING_SLOTS * SLOT_BYTES);

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    localparam logic [1:0] MODE_RX      = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_CHK
    } t_phase;

    typedef struct packed {
        logic       en;
        t_addr      addr;
        logic [7:0] data;
    } t_wr;

    typedef struct packed {
        logic        rd_ok;
        logic        avail;
        logic        committed;
        logic        cks_err;
        logic        ovf;
        logic [15:0] good;
        logic [15:0] bad;
    } t_status;

endpackage

[sv/packet_deframer_xor_ring.sv]
// ----------------------------------------------------------------------------
// packet_deframer_xor_ring
// Sync/length/XOR frame deframer with a ring of received packets.
// Throughput: 1 transaction per cycle while the master side accepts results;
// the packet RAM read port is registered into the result stage, which a
// separate output register backs up.
// Reset: synchronous, active low; clears parser, ring pointers and counters.
// Packet RAM contents are not cleared; the slave side is not ready in reset.
// ----------------------------------------------------------------------------
module packet_deframer_xor_ring
    import pdxr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // rx_byte[7:0], read_index[15:8]
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // mode[1:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // read_data[7:0], packet_available[8],
                                                // packet_committed[9],
                                                // checksum_error[10],
                                                // ring_overflow[11],
                                                // good_packets[27:12],
                                                // bad_packets[43:28], zero[47:44]
);

    t_wr     wr;
    t_addr   rd_addr;
    t_status status;
    logic [7:0] mem_q;

    logic    r_live;
    logic    r_st_valid;
    t_status r_st;
    logic    r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    logic adv_out;
    logic take;
    logic load_out;

    assign adv_out    = !r_m_valid || i_m_tready;
    assign o_s_tready = r_live && (!r_st_valid || adv_out);
    assign take       = i_s_tvalid && o_s_tready;
    assign load_out   = r_st_valid && adv_out;

    pdxr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_mode       (i_s_tuser[1:0]),
        .i_rx_byte    (i_s_tdata[7:0]),
        .i_read_index (i_s_tdata[15:8]),
        .o_wr         (wr),
        .o_rd_addr    (rd_addr),
        .o_status     (status)
    );

    pdxr_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (take),
        .i_raddr (rd_addr),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= 1'b0;
            r_st_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (take) begin
                r_st_valid <= 1'b1;
            end else if (load_out) begin
                r_st_valid <= 1'b0;
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_st <= status;
        end
        if (load_out) begin
            r_m_tdata <= {4'b0, r_st.bad, r_st.good, r_st.ovf, r_st.cks_err,
                          r_st.committed, r_st.avail, r_st.rd_ok ? mem_q : 8'h00};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;

endmodule

[sv/pdxr_ram.sv]
// ----------------------------------------------------------------------------
// pdxr_ram
// Packet ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pdxr_ram
    import pdxr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_we,
    input  t_addr      i_waddr,
    input  logic [7:0] i_wdata,
    input  logic       i_re,
    input  t_addr      i_raddr,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [RING_SLOTS*SLOT_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/pdxr_parser.sv]
// ----------------------------------------------------------------------------
// pdxr_parser
// Frame parser, checksum, ring pointers and packet counters.
// ----------------------------------------------------------------------------
module pdxr_parser
    import pdxr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_read_index,
    output t_wr        o_wr,
    output t_addr      o_rd_addr,
    output t_status    o_status
);

    function automatic t_slot f_next_slot(input t_slot s);
        f_next_slot = (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : t_slot'(s + 1'b1);
    endfunction

    function automatic t_addr f_addr(input t_slot s, input logic [7:0] off);
        f_addr = t_addr'(ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off));
    endfunction

    t_phase      r_phase, n_phase;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_fill, n_fill;
    t_slot       r_wslot, n_wslot;
    t_slot       r_rslot, n_rslot;
    logic [15:0] r_good, n_good;
    logic [15:0] r_bad, n_bad;

    logic       rx_step;
    logic [7:0] fill_inc;
    logic [7:0] wr_off;
    logic       avail;
    logic       committed, cks_err, ovf;
    t_slot      wnext;

    assign rx_step  = i_take && (i_mode == MODE_RX);
    assign fill_inc = r_fill + 8'd1;
    assign avail    = (r_rslot != r_wslot);
    assign wnext    = f_next_slot(r_wslot);
    assign wr_off   = (r_phase == PH_CMD) ? 8'd0 : r_fill;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (rx_step) begin
            case (r_phase)
                PH_CMD:  n_phase = PH_LEN;
                PH_LEN:  n_phase = (i_rx_byte != 8'd0) ? PH_DATA : PH_CHK;
                PH_DATA: n_phase = (fill_inc >= r_len) ? PH_CHK : PH_DATA;
                PH_CHK:  n_phase = PH_HUNT;
                default: n_phase = (i_rx_byte == SYNC_BYTE) ? PH_CMD : PH_HUNT;
            endcase
        end
    end

    // datapath
    always_comb begin
        n_xor     = r_xor;
        n_len     = r_len;
        n_fill    = r_fill;
        n_wslot   = r_wslot;
        n_rslot   = r_rslot;
        n_good    = r_good;
        n_bad     = r_bad;
        committed = 1'b0;
        cks_err   = 1'b0;
        ovf       = 1'b0;
        o_wr.en   = 1'b0;
        o_wr.addr = f_addr(r_wslot, wr_off);
        o_wr.data = i_rx_byte;
        if (rx_step) begin
            case (r_phase)
                PH_CMD: begin
                    o_wr.en = 1'b1;
                    n_fill  = 8'd1;
                    n_xor   = i_rx_byte;
                end
                PH_LEN: begin
                    o_wr.en = ({1'b0, r_fill} < 9'(SLOT_BYTES));
                    n_fill  = fill_inc;
                    n_len   = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                end
                PH_DATA: begin
                    o_wr.en = ({1'b0, r_fill} < 9'(SLOT_BYTES));
                    n_fill  = fill_inc;
                    n_xor   = r_xor ^ i_rx_byte;
                end
                PH_CHK: begin
                    n_fill = 8'd0;
                    if (i_rx_byte == r_xor) begin
                        if (wnext == r_rslot) begin
                            ovf = 1'b1;
                        end else begin
                            n_wslot   = wnext;
                            n_good    = r_good + 16'd1;
                            committed = 1'b1;
                        end
                    end else begin
                        n_bad   = r_bad + 16'd1;
                        cks_err = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_take && (i_mode == MODE_RELEASE) && avail) begin
            n_rslot = f_next_slot(r_rslot);
        end
    end

    assign o_rd_addr          = f_addr(r_rslot, i_read_index);
    assign o_status.rd_ok     = (i_mode == MODE_READ) && avail &&
                                ({1'b0, i_read_index} < 9'(SLOT_BYTES));
    assign o_status.avail     = (n_rslot != n_wslot);
    assign o_status.committed = committed;
    assign o_status.cks_err   = cks_err;
    assign o_status.ovf       = ovf;
    assign o_status.good      = n_good;
    assign o_status.bad       = n_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_xor   <= '0;
            r_len   <= '0;
            r_fill  <= '0;
            r_wslot <= '0;
            r_rslot <= '0;
            r_good  <= '0;
            r_bad   <= '0;
        end else begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_len   <= n_len;
            r_fill  <= n_fill;
            r_wslot <= n_wslot;
            r_rslot <= n_rslot;
            r_good  <= n_good;
            r_bad   <= n_bad;
        end
    end

endmodule

[sv/pdxr_checker.sv]
// ----------------------------------------------------------------------------
// pdxr_checker
// Port-level checks on the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_deframer_xor_ring_assert.svh"

module pdxr_checker
    import pdxr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic [IN_TUSER_W-1:0]  i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    `PDXR_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
    `PDXR_ASSERT(a_commit_avail, o_m_tvalid && o_m_tdata[9] |-> o_m_tdata[8], "commit without packet available")
    `PDXR_ASSERT(a_ovf_avail, o_m_tvalid && o_m_tdata[11] |-> o_m_tdata[8] && !o_m_tdata[9], "overflow with ring not full")
    `PDXR_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_m_tvalid && !o_s_tready, "handshake active after reset")

endmodule

bind packet_deframer_xor_ring pdxr_checker u_pdxr_checker (.*);

[bench/pdxr_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdxr_frame_checker
// Watches both stream channels of the packet deframer. Every accepted input
// transaction is run through a local model of the frame parser and packet
// ring, and the status it should produce is queued. Every accepted output
// transaction is compared field by field with the oldest queued status.
// ----------------------------------------------------------------------------
module pdxr_frame_checker
    import pdxr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // rx_byte[7:0], read_index[15:8]
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // mode[1:0]
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // read_data[7:0], packet_available[8],
                                                // packet_committed[9],
                                                // checksum_error[10],
                                                // ring_overflow[11],
                                                // good_packets[27:12],
                                                // bad_packets[43:28], zero[47:44]
    input  logic                   i_run_done,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_commits,
    output int                     o_cks_errors,
    output int                     o_overflows
);

    typedef struct packed {
        logic [7:0]  read_data;
        logic        avail;
        logic        committed;
        logic        cks_err;
        logic        ovf;
        logic [15:0] good;
        logic [15:0] bad;
    } t_frame_status;

    t_frame_status status_due[$];

    t_phase      phase;
    logic [7:0]  xor_acc;
    logic [7:0]  frame_len;
    logic [7:0]  fill;
    t_slot       wr_slot;
    t_slot       rd_slot;
    logic [15:0] good_cnt;
    logic [15:0] bad_cnt;
    logic [7:0]  pkt_mem [RING_SLOTS*SLOT_BYTES];
    bit          leftovers_done;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_commits      = 0;
        o_cks_errors   = 0;
        o_overflows    = 0;
        leftovers_done = 1'b0;
        foreach (pkt_mem[i]) pkt_mem[i] = '0;
    end

    function automatic t_slot slot_after(t_slot s);
        if (int'(s) + 1 >= RING_SLOTS) begin
            return t_slot'(0);
        end
        return t_slot'(s + 1'b1);
    endfunction

    function automatic void keep_byte(logic [7:0] b);
        if (int'(fill) < SLOT_BYTES) begin
            pkt_mem[int'(wr_slot) * SLOT_BYTES + int'(fill)] = b;
        end
        fill = fill + 8'd1;
    endfunction

    function automatic void clear_parser();
        phase     = PH_HUNT;
        xor_acc   = '0;
        frame_len = '0;
        fill      = '0;
        wr_slot   = '0;
        rd_slot   = '0;
        good_cnt  = '0;
        bad_cnt   = '0;
    endfunction

    function automatic t_frame_status deframe_step(logic [IN_TUSER_W-1:0] mode,
                                                   logic [7:0] rx, logic [7:0] idx);
        t_frame_status r;
        t_slot         nxt;
        logic          had_pkt;
        r       = '0;
        had_pkt = (rd_slot != wr_slot);
        case (mode)
            MODE_RX: begin
                case (phase)
                    PH_CMD: begin
                        fill = '0;
                        keep_byte(rx);
                        xor_acc = rx;
                        phase   = PH_LEN;
                    end
                    PH_LEN: begin
                        keep_byte(rx);
                        frame_len = rx;
                        xor_acc   = xor_acc ^ rx;
                        if (rx != 8'd0) begin
                            phase = PH_DATA;
                        end else begin
                            phase = PH_CHK;
                        end
                    end
                    PH_DATA: begin
                        keep_byte(rx);
                        xor_acc = xor_acc ^ rx;
                        if (fill >= frame_len) phase = PH_CHK;
                    end
                    PH_CHK: begin
                        if (rx == xor_acc) begin
                            nxt = slot_after(wr_slot);
                            if (nxt == rd_slot) begin
                                r.ovf = 1'b1;
                            end else begin
                                wr_slot     = nxt;
                                good_cnt    = good_cnt + 16'd1;
                                r.committed = 1'b1;
                            end
                        end else begin
                            bad_cnt   = bad_cnt + 16'd1;
                            r.cks_err = 1'b1;
                        end
                        phase = PH_HUNT;
                        fill  = '0;
                    end
                    default: begin
                        if (rx == SYNC_BYTE) begin
                            phase = PH_CMD;
                        end else begin
                            phase = PH_HUNT;
                        end
                    end
                endcase
            end
            MODE_READ: begin
                if (had_pkt && int'(idx) < SLOT_BYTES) begin
                    r.read_data = pkt_mem[int'(rd_slot) * SLOT_BYTES + int'(idx)];
                end
            end
            MODE_RELEASE: begin
                if (had_pkt) rd_slot = slot_after(rd_slot);
            end
            default: ;
        endcase
        r.avail = (rd_slot != wr_slot);
        r.good  = good_cnt;
        r.bad   = bad_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_status due;
        if (!i_rst_n) begin
            clear_parser();
            status_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                status_due.push_back(deframe_step(i_s_tuser, i_s_tdata[7:0],
                                                  i_s_tdata[15:8]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (status_due.size() == 0) begin
                    $error("result transaction with nothing expected: tdata %0h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    due = status_due.pop_front();
                    check_field("read_data", due.read_data, i_m_tdata[7:0]);
                    check_field("packet_available", due.avail, i_m_tdata[8]);
                    check_field("packet_committed", due.committed, i_m_tdata[9]);
                    check_field("checksum_error", due.cks_err, i_m_tdata[10]);
                    check_field("ring_overflow", due.ovf, i_m_tdata[11]);
                    check_field("good_packets", due.good, i_m_tdata[27:12]);
                    check_field("bad_packets", due.bad, i_m_tdata[43:28]);
                    check_field("zero", 16'd0, i_m_tdata[47:44]);
                    if (due.committed) o_commits++;
                    if (due.cks_err) o_cks_errors++;
                    if (due.ovf) o_overflows++;
                end
            end
            if (i_run_done && !leftovers_done) begin
                leftovers_done = 1'b1;
                if (status_due.size() != 0) begin
                    $error("%0d expected results never arrived", status_due.size());
                    o_fail_count++;
                end
            end
        end
        o_pending = status_due.size();
    end

endmodule

[bench/tb_packet_deframer_xor_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_deframer_xor_ring
// Drives the deframer with a short directed sequence (empty-ring accesses,
// unused mode, zero and one byte frames, a checksum failure), then one frame
// per slot so that the low bytes of every slot of the packet RAM hold data,
// then random frames mixed with reads, releases and line noise. Both sides
// idle at random; the output side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_packet_deframer_xor_ring;
    import pdxr_pkg::*;

    localparam int         CLK_PERIOD      = 12;
    localparam int         RESET_CYCLES    = 6;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         IDLE_PCT        = 12;
    localparam int         RANDOM_ITEMS    = 900;
    localparam int         BLOCK_ITEMS     = 120;
    localparam int         HOLD_AT         = 250;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         QUIET_FROM      = 600;
    localparam int         QUIET_TO        = 850;
    localparam int         FULL_LEN        = 255;
    localparam int         FILL_LEN        = 40;
    // positions 0 to FILL_LEN-1 of every slot are written before random reads
    localparam int         LAST_SAFE_INDEX = FILL_LEN - 1;
    localparam int         DRAIN_LIMIT     = 5000;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;   // rx_byte[7:0], read_index[15:8]
    logic [IN_TUSER_W-1:0]  i_s_tuser  = '0;   // mode[1:0]
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // read_data[7:0], packet_available[8],
                                               // packet_committed[9],
                                               // checksum_error[10],
                                               // ring_overflow[11],
                                               // good_packets[27:12],
                                               // bad_packets[43:28], zero[47:44]

    logic run_done = 1'b0;
    logic quiet    = 1'b0;
    logic hold_req = 1'b0;

    int fail_count;
    int pending;
    int commits;
    int cks_errors;
    int overflows;
    int items_sent    = 0;
    int frames_sent   = 0;
    int reads_sent    = 0;
    int releases_sent = 0;
    int release_pct   = 40;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    packet_deframer_xor_ring DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    pdxr_frame_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_run_done   (run_done),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_commits    (commits),
        .o_cks_errors (cks_errors),
        .o_overflows  (overflows)
    );

    task automatic put_item(input logic [IN_TUSER_W-1:0] mode, input logic [7:0] rx,
                            input logic [7:0] idx);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {idx, rx};
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // only once every slot has been filled: reads then never hit unwritten RAM
    task automatic consumer_op();
        if ($urandom_range(99) < release_pct) begin
            put_item(MODE_RELEASE, 8'($urandom), 8'($urandom));
            releases_sent++;
        end else begin
            put_item(MODE_READ, 8'($urandom), 8'($urandom_range(LAST_SAFE_INDEX)));
            reads_sent++;
        end
    endtask

    // keep = 0 sends the whole frame, otherwise only its first keep bytes
    task automatic send_frame(input logic [7:0] cmd, input int len, input bit good,
                              input int keep, input bit mixed);
        logic [7:0] frame_bytes[$];
        logic [7:0] acc;
        int         n_data;
        int         n_send;
        n_data      = (len == 0) ? 0 : ((len < 3) ? 1 : len - 2);
        frame_bytes = {SYNC_BYTE, cmd, 8'(len)};
        acc         = cmd ^ 8'(len);
        repeat (n_data) begin
            frame_bytes.push_back(8'($urandom));
            acc = acc ^ frame_bytes[$];
        end
        frame_bytes.push_back(good ? acc : acc ^ 8'($urandom_range(1, 255)));
        n_send = (keep <= 0 || keep > frame_bytes.size()) ? frame_bytes.size() : keep;
        for (int i = 0; i < n_send; i++) begin
            if (mixed && $urandom_range(99) < 15) consumer_op();
            put_item(MODE_RX, frame_bytes[i], 8'($urandom));
        end
        frames_sent++;
    endtask

    initial begin : stimulus
        int rand_start;
        int done_here;
        int block;
        int pick;
        int len;
        int guard;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ring empty, parser hunting
        put_item(MODE_READ, 8'h00, 8'hFF);
        put_item(MODE_RELEASE, 8'hFF, 8'h00);
        put_item(MODE_UNUSED, 8'hFF, 8'hFF);
        put_item(MODE_RX, 8'h00, 8'h00);
        send_frame(8'h00, 0, 1'b1, 0, 1'b0);
        put_item(MODE_READ, 8'h00, 8'h00);
        put_item(MODE_READ, 8'h00, 8'h01);
        send_frame(8'hFF, 1, 1'b0, 0, 1'b0);
        send_frame(8'h80, 1, 1'b1, 0, 1'b0);
        put_item(MODE_RELEASE, 8'h00, 8'h00);
        put_item(MODE_READ, 8'h00, 8'h02);
        put_item(MODE_RELEASE, 8'h00, 8'h00);

        // fill the low bytes of every slot
        repeat (RING_SLOTS) begin
            send_frame(8'($urandom), FILL_LEN, 1'b1, 0, 1'b0);
            put_item(MODE_RELEASE, 8'($urandom), 8'($urandom));
        end

        rand_start = items_sent;
        block      = -1;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            done_here = items_sent - rand_start;
            if (done_here / BLOCK_ITEMS != block) begin
                block       = done_here / BLOCK_ITEMS;
                // alternate filling the ring up and draining it
                release_pct = (block % 2 == 0) ? $urandom_range(0, 15) : $urandom_range(30, 80);
            end
            if (!hold_req && done_here >= HOLD_AT) hold_req <= 1'b1;
            quiet <= (done_here >= QUIET_FROM && done_here < QUIET_TO);
            pick = $urandom_range(99);
            if (pick < 40) begin
                len = $urandom_range(99);
                if (len < 2) begin
                    len = $urandom_range(13, FULL_LEN);
                end else if (len < 10) begin
                    len = $urandom_range(13, 40);
                end else begin
                    len = $urandom_range(0, 12);
                end
                send_frame(8'($urandom), len, $urandom_range(99) < 80,
                           ($urandom_range(99) < 7) ? $urandom_range(1, 3) : 0, 1'b1);
            end else if (pick < 80) begin
                consumer_op();
            end else if (pick < 93) begin
                put_item(MODE_RX, ($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom),
                         8'($urandom));
            end else begin
                put_item(MODE_UNUSED, 8'($urandom), 8'($urandom));
            end
        end
        i_s_tvalid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        run_done <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Run covered %0d transactions in, %0d frames: %0d committed, %0d bad checksums, %0d ring overflows",
                 items_sent, frames_sent, commits, cks_errors, overflows);
        $display("Random reads %0d, releases %0d; output held off once for %0d cycles",
                 reads_sent, releases_sent, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("[packet_deframer_xor_ring] OK");
        end else begin
            $display("[packet_deframer_xor_ring] ERROR");
        end
        $finish;
    end

    initial begin : sink
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("[packet_deframer_xor_ring] ERROR");
        $finish;
    end

endmodule
